### rtl/core/rtsw_pkg.sv
// Shared constants, types and helper functions for the remap table block.
package rtsw_pkg;

    localparam int ENTRIES = 1024;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int IDX_W   = 10;
    localparam int LBL_W   = 10;

    typedef logic [1:0] t_op;

    localparam t_op OP_MOVE  = 2'd0;
    localparam t_op OP_SWAP  = 2'd1;
    localparam t_op OP_QUERY = 2'd2;
    localparam t_op OP_NOP   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic accept;
        logic mv_wr;
        logic sw_rd_b;
        logic sw_wr1;
        logic sw_wr2;
        logic qr_rd2;
        logic qr_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] v);
        logic [IDX_W+ADDR_W-1:0] w;
        w = {{ADDR_W{1'b0}}, v};
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [LBL_W-1:0] to_lbl(input logic [ADDR_W-1:0] v);
        logic [LBL_W+ADDR_W-1:0] w;
        w = {{LBL_W{1'b0}}, v};
        return w[LBL_W-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] v);
        return ({{(32-IDX_W){1'b0}}, v} < 32'(ENTRIES));
    endfunction

endpackage

### rtl/core/remap_table_with_label_swap_top.sv
// Top level: permutation table with label swap and inverse label table.
// Each operation is sequenced through the one read port of each table, so a new operation
// is taken only in idle; busy stays high while an operation is in flight.
// A query's strobe o_valid is registered from state ST_QR_OUT, which follows ST_QR_RD2.
// The receiver cannot stall: each result is shown for exactly one cycle.
// After reset the block clears all three tables to the identity, one entry a cycle,
// with busy high until all ENTRIES (1024) entries are written.
module remap_table_with_label_swap_top
    import rtsw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_operation,
    input  logic [IDX_W-1:0] i_first_index,
    input  logic [IDX_W-1:0] i_second_index,
    output logic             o_valid,
    output logic [LBL_W-1:0] o_label_of_item
);

    // The controller walks each operation through its table accesses. A move reads the
    // slot of the target label and then writes it into the item's entry. A swap reads
    // the slots of both labels in turn and then writes the label and inverse tables in
    // ST_SW_WR1/2. A query reads the item's slot, then that slot's label, and registers it.
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    ctrl_busy;

    rtsw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (ctrl_busy)
    );

    rtsw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_operation),
        .i_first_index   (i_first_index),
        .i_second_index  (i_second_index),
        .o_sts           (sts),
        .o_label_of_item (o_label_of_item),
        .o_valid         (o_valid)
    );

    assign busy = ctrl_busy;

`ifndef SYNTHESIS
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_operation == OP_QUERY), 3))
        else $error("result word without a query three cycles before");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_move_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_MOVE)) |=> busy)
        else $error("move did not hold busy for its write cycle");
`endif

endmodule

### rtl/core/rtsw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rtsw_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rtsw_dp.sv
// Datapath: the three tables, operand registers, clear counter and result register.
module rtsw_dp
    import rtsw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  t_op              i_operation,
    input  logic [IDX_W-1:0] i_first_index,
    input  logic [IDX_W-1:0] i_second_index,
    output t_dp_sts          o_sts,
    output logic [LBL_W-1:0] o_label_of_item,
    output logic             o_valid
);

    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ADDR_W-1:0] r_a, r_b, r_sa, r_sb;
    logic              r_ok;
    logic [LBL_W-1:0]  r_label;
    logic              r_valid;

    logic              is_we, ls_we, sl_we;
    logic [ADDR_W-1:0] is_waddr, ls_waddr, sl_waddr;
    logic [ADDR_W-1:0] is_wdata, ls_wdata, sl_wdata;
    logic [ADDR_W-1:0] is_raddr, ls_raddr, sl_raddr;
    logic [ADDR_W-1:0] is_rdata, ls_rdata, sl_rdata;
    logic              clr_last;

    assign clr_last       = (r_clr == ADDR_W'(ENTRIES - 1));
    assign o_sts.clr_last = clr_last;

    always_comb begin
        n_clr = r_clr;
        if (i_cmd.clr) begin
            n_clr = clr_last ? '0 : r_clr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_clr   <= n_clr;
            r_valid <= i_cmd.qr_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a  <= to_addr(i_first_index);
            r_b  <= to_addr(i_second_index);
            r_ok <= in_range(i_first_index) &&
                    ((i_operation == OP_QUERY) || in_range(i_second_index));
        end
        if (i_cmd.sw_rd_b) begin
            r_sa <= ls_rdata;
        end
        if (i_cmd.sw_wr1) begin
            r_sb <= ls_rdata;
        end
        if (i_cmd.qr_out) begin
            r_label <= r_ok ? to_lbl(sl_rdata) : '0;
        end
    end

    // Item to slot table.
    assign is_we    = i_cmd.clr || (i_cmd.mv_wr && r_ok);
    assign is_waddr = i_cmd.clr ? r_clr : r_a;
    assign is_wdata = i_cmd.clr ? r_clr : ls_rdata;
    assign is_raddr = to_addr(i_first_index);

    // Label to slot table.
    assign ls_we    = i_cmd.clr || ((i_cmd.sw_wr1 || i_cmd.sw_wr2) && r_ok);
    assign ls_waddr = i_cmd.clr ? r_clr : (i_cmd.sw_wr1 ? r_b : r_a);
    assign ls_wdata = i_cmd.clr ? r_clr : (i_cmd.sw_wr1 ? r_sa : r_sb);
    assign ls_raddr = i_cmd.sw_rd_b ? r_b :
                      ((i_operation == OP_MOVE) ? to_addr(i_second_index)
                                                : to_addr(i_first_index));

    // Slot to label table.
    assign sl_we    = ls_we;
    assign sl_waddr = i_cmd.clr ? r_clr : (i_cmd.sw_wr1 ? r_sa : r_sb);
    assign sl_wdata = i_cmd.clr ? r_clr : (i_cmd.sw_wr1 ? r_b : r_a);
    assign sl_raddr = is_rdata;

    rtsw_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_item_slot (
        .i_clk   (i_clk),
        .i_we    (is_we),
        .i_waddr (is_waddr),
        .i_wdata (is_wdata),
        .i_raddr (is_raddr),
        .o_rdata (is_rdata)
    );

    rtsw_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_label_slot (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_waddr),
        .i_wdata (ls_wdata),
        .i_raddr (ls_raddr),
        .o_rdata (ls_rdata)
    );

    rtsw_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_slot_label (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_waddr),
        .i_wdata (sl_wdata),
        .i_raddr (sl_raddr),
        .o_rdata (sl_rdata)
    );

    assign o_label_of_item = r_label;
    assign o_valid         = r_valid;

endmodule

### rtl/core/rtsw_ctrl.sv
// Controller: state machine that sequences table clearing and each operation.
module rtsw_ctrl
    import rtsw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_op     i_operation,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MV_WR  = 3'd2;
    localparam logic [2:0] ST_SW_RDB = 3'd3;
    localparam logic [2:0] ST_SW_WR1 = 3'd4;
    localparam logic [2:0] ST_SW_WR2 = 3'd5;
    localparam logic [2:0] ST_QR_RD2 = 3'd6;
    localparam logic [2:0] ST_QR_OUT = 3'd7;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_MOVE:  n_state = ST_MV_WR;
                        OP_SWAP:  n_state = ST_SW_RDB;
                        OP_QUERY: n_state = ST_QR_RD2;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MV_WR:  n_state = ST_IDLE;
            ST_SW_RDB: n_state = ST_SW_WR1;
            ST_SW_WR1: n_state = ST_SW_WR2;
            ST_SW_WR2: n_state = ST_IDLE;
            ST_QR_RD2: n_state = ST_QR_OUT;
            ST_QR_OUT: n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.clr     = (r_state == ST_CLEAR);
        o_cmd.accept  = accept;
        o_cmd.mv_wr   = (r_state == ST_MV_WR);
        o_cmd.sw_rd_b = (r_state == ST_SW_RDB);
        o_cmd.sw_wr1  = (r_state == ST_SW_WR1);
        o_cmd.sw_wr2  = (r_state == ST_SW_WR2);
        o_cmd.qr_rd2  = (r_state == ST_QR_RD2);
        o_cmd.qr_out  = (r_state == ST_QR_OUT);
    end

    assign o_busy = (r_state != ST_IDLE);

`ifndef SYNTHESIS
    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && !i_sts.clr_last) |=> (r_state == ST_CLEAR))
        else $error("clearing pass left early");

    a_query_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.qr_out |-> $past(o_cmd.qr_rd2))
        else $error("query result step without its second read");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sw_wr2 |-> $past(o_cmd.sw_wr1) && $past(o_cmd.sw_rd_b, 2))
        else $error("swap steps out of order");
`endif

endmodule
